/* rtl/mff_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mff_pkg: shared types and constants of the multichannel frame FIFO
// Field widths, operation and frame kind codes, register indexes and the
// result metadata that travels from the sequencer to the output queue.
// ----------------------------------------------------------------------------
package mff_pkg;

	// Field widths fixed by the stream format.
	localparam int OP_W        = 2;
	localparam int COUNT_W     = 7;
	localparam int SAMPLE_W    = 32;
	localparam int NUM_SAMPLES = 4;
	localparam int CAP_W       = 13;
	localparam int CHAN_W      = 3;
	localparam int FILL_W      = 13;
	localparam int KIND_W      = 2;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 13;

	// Packed stream widths; the tdata widths are rounded up to whole bytes.
	localparam int S_TDATA_W = 136;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 152;
	localparam int M_TUSER_W = 2;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_PUSH    = 2'd0;
	localparam logic [OP_W-1:0] OP_POP     = 2'd1;
	localparam logic [OP_W-1:0] OP_DISCARD = 2'd2;
	localparam logic [OP_W-1:0] OP_FLUSH   = 2'd3;

	// Frame kind codes of a result.
	localparam logic [KIND_W-1:0] KIND_STORED   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_UNDERRUN = 2'd1;
	localparam logic [KIND_W-1:0] KIND_STATUS   = 2'd2;

	// Configuration register indexes and reset values.
	localparam logic [CFG_INDEX_W-1:0] REG_CAPACITY = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_CHANNELS = 1'd1;
	localparam logic [CAP_W-1:0]       CAP_RESET    = 13'd4096;
	localparam logic [CHAN_W-1:0]      CHAN_RESET   = 3'd2;

	// Metadata of one result.
	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [COUNT_W-1:0] moved;
		logic [FILL_W-1:0]  fill;
		logic               last;
	} mff_meta_t;

endpackage

/* rtl/mff_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mff_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module mff_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/mff_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mff_ctrl: request sequencer of the frame FIFO
// Holds the configuration, the ring pointers and the fill count, writes pushed
// frames into the frame store and issues one result slot per cycle while the output
// queue grants credit, reading the store for every stored frame of a pop.
// ----------------------------------------------------------------------------
module mff_ctrl #(
	parameter int MAX_FRAMES   = 4096,
	parameter int MAX_CHANNELS = 4,
	parameter int MAX_BURST    = 64
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	// Request side
	input  logic                                           s_valid,
	output logic                                           s_ready,
	input  logic [mff_pkg::OP_W-1:0]                       op,
	input  logic [mff_pkg::COUNT_W-1:0]                    frame_count,
	input  logic [mff_pkg::NUM_SAMPLES*mff_pkg::SAMPLE_W-1:0] samples,
	// Configuration
	input  logic                                           wr_en,
	input  logic [mff_pkg::CFG_INDEX_W-1:0]                wr_index,
	input  logic [mff_pkg::CFG_DATA_W-1:0]                 wr_data,
	// Frame store
	output logic                                           ram_we,
	output logic [$clog2(MAX_FRAMES)-1:0]                  ram_waddr,
	output logic [((MAX_CHANNELS < 4) ? MAX_CHANNELS : 4)*mff_pkg::SAMPLE_W-1:0] ram_wdata,
	output logic                                           ram_re,
	output logic [$clog2(MAX_FRAMES)-1:0]                  ram_raddr,
	input  logic [((MAX_CHANNELS < 4) ? MAX_CHANNELS : 4)*mff_pkg::SAMPLE_W-1:0] ram_rdata,
	// Result slots towards the output queue
	input  logic                                           credit_ok,
	output logic                                           slot_valid,
	output mff_pkg::mff_meta_t                             slot_meta,
	output logic [((MAX_CHANNELS < 4) ? MAX_CHANNELS : 4)*mff_pkg::SAMPLE_W-1:0] slot_data
);
	import mff_pkg::*;

	localparam int AW    = $clog2(MAX_FRAMES);
	localparam int CW    = $clog2(MAX_FRAMES + 1);
	localparam int MW    = (CW > COUNT_W) ? CW : COUNT_W;
	localparam int LANES = (MAX_CHANNELS < NUM_SAMPLES) ? MAX_CHANNELS : NUM_SAMPLES;
	localparam int DW    = LANES * SAMPLE_W;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_GEN  = 1'b1;

	logic                state_q;
	logic [CAP_W-1:0]    capacity_q;
	logic [CHAN_W-1:0]   channels_q;
	logic [AW-1:0]       rp_q;
	logic [AW-1:0]       wp_q;
	logic [CW-1:0]       held_q;
	logic [COUNT_W-1:0]  rem_q;
	logic [COUNT_W-1:0]  stored_q;
	logic [COUNT_W-1:0]  moved_q;
	logic [FILL_W-1:0]   fill_q;
	logic                valid_s1;
	mff_meta_t           meta_s1;

	logic [CW-1:0]       cap_eff;
	logic [CHAN_W-1:0]   chans;
	logic [COUNT_W-1:0]  cnt;
	logic [COUNT_W-1:0]  n_avail;
	logic                can_push;
	logic                pop_burst;
	logic [CW:0]         disc_sum;
	logic [AW-1:0]       rp_disc;
	logic                accept;
	logic                cfg_wr;
	logic                gen_issue;
	logic [COUNT_W-1:0]  total_a;
	logic [COUNT_W-1:0]  moved_a;
	logic [CW-1:0]       held_a;
	logic [KIND_W-1:0]   kind_a;
	logic [NUM_SAMPLES*SAMPLE_W-1:0] masked;
	mff_meta_t           meta_next;

	// Advance a ring pointer, wrapping at the capacity in use.
	function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p,
	                                           input logic [CW-1:0] c);
		logic [CW:0] inc;
		inc = (CW+1)'(p) + (CW+1)'(1);
		return (inc >= (CW+1)'(c)) ? '0 : AW'(inc);
	endfunction

	// Effective capacity and channel count.
	always_comb begin
		cap_eff = (32'(capacity_q) > 32'(MAX_FRAMES)) ? CW'(MAX_FRAMES) : CW'(capacity_q);
		chans   = (32'(channels_q) > 32'(LANES)) ? CHAN_W'(LANES) : channels_q;
	end

	// Request decode.
	always_comb begin
		cnt       = (frame_count > COUNT_W'(MAX_BURST)) ? COUNT_W'(MAX_BURST) : frame_count;
		n_avail   = (MW'(cnt) < MW'(held_q)) ? cnt : COUNT_W'(held_q);
		can_push  = held_q < cap_eff;
		pop_burst = (op == OP_POP) && (cnt != '0);
		disc_sum  = (CW+1)'(rp_q) + (CW+1)'(n_avail);
		rp_disc   = (disc_sum >= (CW+1)'(cap_eff)) ? AW'(disc_sum - (CW+1)'(cap_eff))
		                                            : AW'(disc_sum);
	end

	// Outcome of the accepted request: moved count, new fill and first slot kind.
	always_comb begin
		total_a = COUNT_W'(1);
		moved_a = '0;
		held_a  = held_q;
		kind_a  = KIND_STATUS;
		case (op)
			OP_PUSH: begin
				if (can_push) begin
					moved_a = COUNT_W'(1);
					held_a  = held_q + CW'(1);
				end
			end
			OP_POP: begin
				if (pop_burst) begin
					total_a = cnt;
					moved_a = n_avail;
					held_a  = held_q - CW'(n_avail);
					kind_a  = (n_avail != '0) ? KIND_STORED : KIND_UNDERRUN;
				end
			end
			OP_DISCARD: begin
				moved_a = n_avail;
				held_a  = held_q - CW'(n_avail);
			end
			default: begin
				held_a = '0;
			end
		endcase
	end

	// Handshake and issue control.
	assign s_ready   = (state_q == ST_IDLE) && credit_ok;
	assign accept    = s_valid && s_ready;
	assign cfg_wr    = wr_en;
	assign gen_issue = (state_q == ST_GEN) && credit_ok;

	// Channels beyond the count in use are stored as zero.
	always_comb begin
		masked = '0;
		for (int j = 0; j < NUM_SAMPLES; j++) begin
			if (j < int'(chans)) begin
				masked[j*SAMPLE_W +: SAMPLE_W] = samples[j*SAMPLE_W +: SAMPLE_W];
			end
		end
	end

	// Frame store ports.
	assign ram_we    = accept && (op == OP_PUSH) && can_push;
	assign ram_waddr = wp_q;
	assign ram_wdata = DW'(masked);
	assign ram_re    = (accept && pop_burst && (n_avail != '0)) ||
	                   (gen_issue && (stored_q != '0));
	assign ram_raddr = rp_q;

	// Metadata of the slot issued this cycle.
	always_comb begin
		if (state_q == ST_IDLE) begin
			meta_next.kind  = kind_a;
			meta_next.moved = moved_a;
			meta_next.fill  = FILL_W'(held_a);
			meta_next.last  = (total_a == COUNT_W'(1));
		end else begin
			meta_next.kind  = (stored_q != '0) ? KIND_STORED : KIND_UNDERRUN;
			meta_next.moved = moved_q;
			meta_next.fill  = fill_q;
			meta_next.last  = (rem_q == COUNT_W'(1));
		end
	end

	// Sequencer, pointers and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			capacity_q <= CAP_RESET;
			channels_q <= CHAN_RESET;
			rp_q       <= '0;
			wp_q       <= '0;
			held_q     <= '0;
			rem_q      <= '0;
			stored_q   <= '0;
		end else if (cfg_wr) begin
			if (wr_index == REG_CAPACITY) begin
				capacity_q <= wr_data[CAP_W-1:0];
			end else begin
				channels_q <= wr_data[CHAN_W-1:0];
			end
			rp_q   <= '0;
			wp_q   <= '0;
			held_q <= '0;
		end else if (accept) begin
			held_q <= held_a;
			case (op)
				OP_PUSH: begin
					if (can_push) begin
						wp_q <= next_ptr(wp_q, cap_eff);
					end
				end
				OP_POP: begin
					if (pop_burst && (n_avail != '0)) begin
						rp_q <= next_ptr(rp_q, cap_eff);
					end
				end
				OP_DISCARD: begin
					rp_q <= rp_disc;
				end
				default: begin
					rp_q <= wp_q;
				end
			endcase
			if (total_a != COUNT_W'(1)) begin
				state_q  <= ST_GEN;
				rem_q    <= total_a - COUNT_W'(1);
				stored_q <= (n_avail != '0) ? n_avail - COUNT_W'(1) : '0;
			end
		end else if (gen_issue) begin
			rem_q <= rem_q - COUNT_W'(1);
			if (stored_q != '0) begin
				stored_q <= stored_q - COUNT_W'(1);
				rp_q     <= next_ptr(rp_q, cap_eff);
			end
			if (rem_q == COUNT_W'(1)) begin
				state_q <= ST_IDLE;
			end
		end
	end

	// Moved count and final fill, shared by every slot of a request.
	always_ff @(posedge clk) begin
		if (accept) begin
			moved_q <= moved_a;
			fill_q  <= FILL_W'(held_a);
		end
	end

	// Slot stage: metadata is registered alongside the store read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || gen_issue;
		end
	end

	always_ff @(posedge clk) begin
		if (accept || gen_issue) begin
			meta_s1 <= meta_next;
		end
	end

	assign slot_valid = valid_s1;
	assign slot_meta  = meta_s1;
	assign slot_data  = (meta_s1.kind == KIND_STORED) ? ram_rdata : '0;

endmodule

/* rtl/mff_outq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mff_outq: two-entry result queue
// Decouples the result stream from the sequencer and grants issue credit
// so that one slot in flight always finds room.
// ----------------------------------------------------------------------------
module mff_outq #(
	parameter int DW = 128
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	input  mff_pkg::mff_meta_t push_meta,
	input  logic [DW-1:0]      push_data,
	output logic               credit_ok,
	output logic               m_valid,
	input  logic               m_ready,
	output mff_pkg::mff_meta_t m_meta,
	output logic [DW-1:0]      m_data
);
	import mff_pkg::*;

	mff_meta_t     meta_q [2];
	logic [DW-1:0] data_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    occ_q;
	logic          pop;
	logic [2:0]    after;

	assign pop     = m_valid && m_ready;
	assign m_valid = (occ_q != 2'd0);
	assign m_meta  = meta_q[rd_ptr_q];
	assign m_data  = data_q[rd_ptr_q];

	// A new slot may issue if the queue keeps a free entry for it.
	assign after     = 3'(occ_q) + 3'(push_valid) - 3'(pop);
	assign credit_ok = (after <= 3'd1);

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			occ_q    <= 2'd0;
		end else begin
			if (push_valid) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			occ_q <= 2'(after);
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push_valid) begin
			meta_q[wr_ptr_q] <= push_meta;
			data_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* rtl/multichannel_frame_fifo_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_frame_fifo_top: circular FIFO of multichannel audio frames
//
// Channel    Direction  Handshake          Contents
// s_*        in         s_tvalid/s_tready  tuser: operation; tdata: frame_count, sample_0..3
// m_*        out        m_tvalid/m_tready  tuser: frame_kind; tlast: last;
//                                          tdata: out_0..3, moved, fill_level
// wr_*       in         wr_en              wr_index, wr_data (no read-back)
//
// The sequencer issues one result slot per cycle while the output queue grants credit:
// a push, discard, flush or empty pop gives one result, a pop of N frames gives N.
// The frame store is read one frame per cycle while stored slots issue; read data is registered.
// A two-entry output queue lets requests keep flowing while results wait.
// Reset clears the pointers and fill; the frame store needs no clearing.
// ----------------------------------------------------------------------------
module multichannel_frame_fifo_top #(
	parameter int MAX_FRAMES   = 4096,
	parameter int MAX_CHANNELS = 4,
	parameter int MAX_BURST    = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// frame_count[6:0], sample_0[38:7], sample_1[70:39], sample_2[102:71],
	// sample_3[134:103]
	input  logic [mff_pkg::S_TDATA_W-1:0]     s_tdata,
	// operation[1:0]
	input  logic [mff_pkg::S_TUSER_W-1:0]     s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// out_0[31:0], out_1[63:32], out_2[95:64], out_3[127:96], moved[134:128],
	// fill_level[147:135]
	output logic [mff_pkg::M_TDATA_W-1:0]     m_tdata,
	// frame_kind[1:0]
	output logic [mff_pkg::M_TUSER_W-1:0]     m_tuser,
	output logic                              m_tlast,
	input  logic                              wr_en,
	input  logic [mff_pkg::CFG_INDEX_W-1:0]   wr_index,
	input  logic [mff_pkg::CFG_DATA_W-1:0]    wr_data
);
	import mff_pkg::*;

	localparam int AW    = $clog2(MAX_FRAMES);
	localparam int LANES = (MAX_CHANNELS < NUM_SAMPLES) ? MAX_CHANNELS : NUM_SAMPLES;
	localparam int DW    = LANES * SAMPLE_W;
	localparam int SW    = NUM_SAMPLES * SAMPLE_W;

	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	logic [DW-1:0]   ram_wdata;
	logic            ram_re;
	logic [AW-1:0]   ram_raddr;
	logic [DW-1:0]   ram_rdata;
	logic            credit_ok;
	logic            slot_valid;
	mff_meta_t       slot_meta;
	logic [DW-1:0]   slot_data;
	mff_meta_t       head_meta;
	logic [DW-1:0]   head_data;

	mff_ctrl #(
		.MAX_FRAMES  (MAX_FRAMES),
		.MAX_CHANNELS(MAX_CHANNELS),
		.MAX_BURST   (MAX_BURST)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_valid    (s_tvalid),
		.s_ready    (s_tready),
		.op         (s_tuser[OP_W-1:0]),
		.frame_count(s_tdata[COUNT_W-1:0]),
		.samples    (s_tdata[COUNT_W +: SW]),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.ram_re     (ram_re),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata),
		.credit_ok  (credit_ok),
		.slot_valid (slot_valid),
		.slot_meta  (slot_meta),
		.slot_data  (slot_data)
	);

	mff_ram #(
		.WIDTH(DW),
		.DEPTH(MAX_FRAMES)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	mff_outq #(
		.DW(DW)
	) u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(slot_valid),
		.push_meta (slot_meta),
		.push_data (slot_data),
		.credit_ok (credit_ok),
		.m_valid   (m_tvalid),
		.m_ready   (m_tready),
		.m_meta    (head_meta),
		.m_data    (head_data)
	);

	// Result packing; channel words above the stored lanes read zero.
	assign m_tdata = M_TDATA_W'({head_meta.fill, head_meta.moved, SW'(head_data)});
	assign m_tuser = head_meta.kind;
	assign m_tlast = head_meta.last;

endmodule

/* rtl/mff_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mff_checker: result stream checks of the frame FIFO
// Watches the result channel of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module mff_checker #(
	parameter int MAX_BURST = 64
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [mff_pkg::M_TDATA_W-1:0] m_tdata,
	input logic [mff_pkg::M_TUSER_W-1:0] m_tuser,
	input logic                          m_tlast
);
	import mff_pkg::*;

	// A stalled result holds its contents.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
		&& $stable(m_tlast))
		else $error("result changed while stalled");

	// A status result is always the only and final result of its request.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_STATUS) |-> m_tlast)
		else $error("status result not marked last");

	// Underrun and status results carry no sample words.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != KIND_STORED) |-> (m_tdata[127:0] == '0))
		else $error("non-stored result carries sample data");

	// A stored frame implies a non-zero moved count within the burst limit.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_STORED) |->
		(m_tdata[134:128] != '0) && (m_tdata[134:128] <= 7'(MAX_BURST)))
		else $error("stored frame with bad moved count");

endmodule

bind multichannel_frame_fifo_top mff_checker #(.MAX_BURST(MAX_BURST)) u_mff_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser),
	.m_tlast (m_tlast)
);

/* tb/sv/multichannel_frame_fifo_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_frame_fifo_top_test: self-checking bench of the frame FIFO
// A local model of the ring (store, pointers, fill, registers) predicts every
// result of each accepted request. A checker compares each delivered result,
// field by field, with the oldest prediction. Directed tests cover reset
// values, register extremes, zero and oversized capacity. Then come a long
// output hold-off and random traffic under several register settings, with
// random gaps on both sides.
// ----------------------------------------------------------------------------
module multichannel_frame_fifo_top_test;
	import mff_pkg::*;

	localparam int MAX_FRAMES   = 4096;
	localparam int MAX_CHANNELS = 4;
	localparam int MAX_BURST    = 64;
	localparam int STALL_LIMIT  = 2000;
	localparam int HOLD_CYCLES  = 300;
	localparam int TAIL_CYCLES  = 20;

	typedef logic [NUM_SAMPLES-1:0][SAMPLE_W-1:0] frame_words_t;

	// One predicted result, as it should leave the master side.
	typedef struct packed {
		frame_words_t       words;
		logic [KIND_W-1:0]  kind;
		logic [COUNT_W-1:0] moved;
		logic [FILL_W-1:0]  fill;
		logic               last;
	} fifo_result_t;

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [S_TDATA_W-1:0]   s_tdata  = '0;
	logic [S_TUSER_W-1:0]   s_tuser  = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [M_TDATA_W-1:0]   m_tdata;
	logic [M_TUSER_W-1:0]   m_tuser;
	logic                   m_tlast;
	logic                   wr_en    = 1'b0;
	logic [CFG_INDEX_W-1:0] wr_index = '0;
	logic [CFG_DATA_W-1:0]  wr_data  = '0;

	// Model of the ring and its registers.
	frame_words_t    frame_copy [0:MAX_FRAMES-1];
	int              rd_slot;
	int              wr_slot;
	int              held;
	logic [CAP_W-1:0]  capacity_reg = CAP_RESET;
	logic [CHAN_W-1:0] channels_reg = CHAN_RESET;

	fifo_result_t expected_results [$];

	int gap_max       = 17;
	int stall_max     = 17;
	bit hold_request  = 1'b0;
	int mismatches    = 0;
	int requests_sent = 0;
	int results_seen  = 0;
	int config_writes = 0;
	int stalled_cycles = 0;

	multichannel_frame_fifo_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic int next_slot(input int p, input int cap);
		return (p + 1 >= cap) ? 0 : p + 1;
	endfunction

	// Works out every result of one accepted request and updates the model.
	task automatic predict_request(input logic [OP_W-1:0] op, input logic [COUNT_W-1:0] req_count,
			input frame_words_t samples);
		int cap;
		int chans;
		int count;
		int n;
		int held_after;
		int p;
		frame_words_t frame;
		fifo_result_t res;
		cap = (int'(capacity_reg) > MAX_FRAMES) ? MAX_FRAMES : int'(capacity_reg);
		chans = int'(channels_reg);
		if (chans > MAX_CHANNELS) chans = MAX_CHANNELS;
		if (chans > NUM_SAMPLES) chans = NUM_SAMPLES;
		count = (int'(req_count) > MAX_BURST) ? MAX_BURST : int'(req_count);
		if (held > cap) held = cap;
		n = (cap == 0) ? 0 : ((count < held) ? count : held);
		res = '0;
		res.kind = KIND_STATUS;
		res.last = 1'b1;
		case (op)
			OP_PUSH: begin
				if (cap != 0 && held < cap && wr_slot < cap) begin
					frame = '0;
					for (int j = 0; j < chans; j++) frame[j] = samples[j];
					frame_copy[wr_slot] = frame;
					wr_slot = next_slot(wr_slot, cap);
					held++;
					res.moved = COUNT_W'(1);
				end
				res.fill = FILL_W'(held);
				expected_results.push_back(res);
			end
			OP_POP: begin
				if (count == 0) begin
					res.fill = FILL_W'(held);
					expected_results.push_back(res);
				end else begin
					// Every frame of the burst reports the fill after the whole request.
					held_after = held - n;
					for (int i = 0; i < count; i++) begin
						res = '0;
						res.moved = COUNT_W'(n);
						res.fill = FILL_W'(held_after);
						res.last = (i == count - 1);
						if (i < n) begin
							p = (rd_slot < cap) ? rd_slot : 0;
							frame = '0;
							for (int j = 0; j < chans; j++) frame[j] = frame_copy[p][j];
							res.words = frame;
							res.kind = KIND_STORED;
							rd_slot = next_slot(p, cap);
						end else begin
							res.kind = KIND_UNDERRUN;
						end
						expected_results.push_back(res);
					end
					held = held_after;
				end
			end
			OP_DISCARD: begin
				for (int i = 0; i < n; i++) rd_slot = next_slot((rd_slot < cap) ? rd_slot : 0, cap);
				held -= n;
				res.moved = COUNT_W'(n);
				res.fill = FILL_W'(held);
				expected_results.push_back(res);
			end
			default: begin
				rd_slot = wr_slot;
				held = 0;
				res.fill = FILL_W'(held);
				expected_results.push_back(res);
			end
		endcase
	endtask

	// Offers one request after a random gap and predicts it once accepted.
	// The valid is left high so that a following request with no gap flows on.
	task automatic send_request(input logic [OP_W-1:0] op, input logic [COUNT_W-1:0] count,
			input frame_words_t samples);
		int gap;
		gap = $urandom_range(gap_max, 0);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {1'b0, samples, count};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_request(op, count, samples);
		requests_sent++;
	endtask

	// Stops offering and waits until every predicted result has arrived.
	task automatic wait_until_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (expected_results.size() != 0);
	endtask

	// Writes both registers on back-to-back edges; each write empties the ring.
	task automatic configure(input logic [CFG_DATA_W-1:0] capacity,
			input logic [CFG_DATA_W-1:0] channel_word);
		wr_en    <= 1'b1;
		wr_index <= REG_CAPACITY;
		wr_data  <= capacity;
		@(posedge clk);
		wr_index <= REG_CHANNELS;
		wr_data  <= channel_word;
		@(posedge clk);
		wr_en <= 1'b0;
		capacity_reg = capacity;
		channels_reg = channel_word[CHAN_W-1:0];
		rd_slot = 0;
		wr_slot = 0;
		held = 0;
		config_writes += 2;
	endtask

	// Reset values: capacity 4096 and two channels.
	task automatic test_reset_defaults();
		send_request(OP_PUSH, 7'h7F, {NUM_SAMPLES{32'hFFFF_FFFF}});
		send_request(OP_PUSH, 7'h00, '0);
		send_request(OP_PUSH, 7'h2A, {32'hA5A5_5A5A, 32'h0123_4567, 32'h89AB_CDEF, 32'h5555_AAAA});
		send_request(OP_POP, 7'd0, '0);
		send_request(OP_POP, 7'd4, '0);
		send_request(OP_POP, 7'h7F, {NUM_SAMPLES{32'hFFFF_FFFF}});
		send_request(OP_DISCARD, 7'd3, '0);
		send_request(OP_FLUSH, 7'd9, '0);
		wait_until_drained();
	endtask

	// Smallest useful ring with the channel count above the limit: a full ring
	// drops a push, and an oversized discard is capped.
	task automatic test_register_extremes();
		configure(13'd2, 13'h1FFF);
		send_request(OP_PUSH, 7'd0, {$urandom, $urandom, $urandom, $urandom});
		send_request(OP_PUSH, 7'd0, {$urandom, $urandom, $urandom, $urandom});
		send_request(OP_PUSH, 7'd0, {$urandom, $urandom, $urandom, $urandom});
		send_request(OP_POP, 7'd1, '0);
		send_request(OP_DISCARD, 7'h7F, '0);
		send_request(OP_PUSH, 7'd1, {$urandom, $urandom, $urandom, $urandom});
		send_request(OP_FLUSH, 7'd0, '0);
		send_request(OP_POP, 7'd1, '0);
		wait_until_drained();
	endtask

	// Zero capacity moves nothing; a pop still returns zero-filled frames.
	task automatic test_zero_capacity();
		configure(13'd0, 13'd4);
		send_request(OP_PUSH, 7'd0, {$urandom, $urandom, $urandom, $urandom});
		send_request(OP_DISCARD, 7'd5, '0);
		send_request(OP_POP, 7'd3, '0);
		wait_until_drained();
	endtask

	// Capacity above the store acts as the store size; no channels are stored.
	task automatic test_oversized_capacity();
		configure(13'h1FFF, 13'd0);
		send_request(OP_PUSH, 7'd0, {$urandom, $urandom, $urandom, $urandom});
		send_request(OP_PUSH, 7'd0, {$urandom, $urandom, $urandom, $urandom});
		send_request(OP_POP, 7'd2, '0);
		wait_until_drained();
	endtask

	// The receiver holds off for a long stretch while pushes keep coming, so
	// the output queue fills and the slave side stalls.
	task automatic test_output_backpressure();
		configure(13'd64, 13'd4);
		gap_max = 0;
		hold_request = 1'b1;
		repeat (40) send_request(OP_PUSH, 7'($urandom), {$urandom, $urandom, $urandom, $urandom});
		send_request(OP_POP, 7'd40, '0);
		wait_until_drained();
		gap_max = 17;
	endtask

	// One setting of the registers followed by random requests, mostly
	// pushes and short pops so that the ring fills, wraps and runs dry.
	task automatic run_random_phase(input logic [CFG_DATA_W-1:0] capacity,
			input logic [CFG_DATA_W-1:0] channel_word, input int items, input int push_pct);
		int roll;
		int sel;
		logic [OP_W-1:0] op;
		logic [COUNT_W-1:0] count;
		configure(capacity, channel_word);
		repeat (items) begin
			roll = $urandom_range(99, 0);
			sel = $urandom_range(99, 0);
			count = 7'($urandom);
			if (roll < push_pct) begin
				op = OP_PUSH;
			end else if (roll < push_pct + (100 - push_pct) * 2 / 3) begin
				op = OP_POP;
				if (sel < 8) count = '0;
				else if (sel < 80) count = COUNT_W'($urandom_range(6, 1));
				else if (sel < 95) count = COUNT_W'($urandom_range(64, 7));
				else count = COUNT_W'($urandom_range(127, 65));
			end else if (roll < 97) begin
				op = OP_DISCARD;
				if (sel < 85) count = COUNT_W'($urandom_range(6, 0));
			end else begin
				op = OP_FLUSH;
			end
			send_request(op, count, {$urandom, $urandom, $urandom, $urandom});
		end
		wait_until_drained();
	endtask

	task automatic test_random_traffic();
		run_random_phase(13'd5, 13'd3, 60, 55);
		run_random_phase(13'd1, 13'd1, 40, 50);
		// A stretch with no idling on either side.
		gap_max = 0;
		stall_max = 0;
		run_random_phase(CFG_DATA_W'($urandom_range(40, 2)),
			CFG_DATA_W'($urandom_range(7, 0)), 60, 60);
		gap_max = 17;
		stall_max = 17;
		run_random_phase(13'd4096, 13'd4, 40, 60);
		run_random_phase(CFG_DATA_W'($urandom_range(8191, 1)), 13'd4, 50, 50);
		run_random_phase(13'd0, CFG_DATA_W'($urandom_range(7, 0)), 20, 50);
	endtask

	// Result side: a random stall before each result, or the long hold-off
	// when a test asks for one.
	initial begin : result_sink
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			stall = $urandom_range(stall_max, 0);
			if (hold_request) begin
				stall = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	task automatic note_mismatch(input fifo_result_t want, input bit unexpected);
		if (mismatches < 10) begin
			if (unexpected)
				$display("%0t: result with nothing expected: kind %0d moved %0d fill %0d",
					$realtime, m_tuser, m_tdata[134:128], m_tdata[147:135]);
			else begin
				$display("%0t: mismatch", $realtime);
				$display("  expected kind %0d moved %0d fill %0d last %0b words %h",
					want.kind, want.moved, want.fill, want.last, want.words);
				$display("  actual   kind %0d moved %0d fill %0d last %0b words %h",
					m_tuser, m_tdata[134:128], m_tdata[147:135], m_tlast, m_tdata[127:0]);
			end
		end
		mismatches++;
	endtask

	// Each delivered result against the oldest prediction.
	always @(posedge clk) begin : result_check
		fifo_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				note_mismatch('0, 1'b1);
			end else begin
				want = expected_results.pop_front();
				if (m_tdata[127:0] !== want.words || m_tuser !== want.kind
						|| m_tdata[134:128] !== want.moved || m_tdata[147:135] !== want.fill
						|| m_tlast !== want.last)
					note_mismatch(want, 1'b0);
			end
		end
	end

	// Ends the run if nothing moves on any port for too long.
	always @(posedge clk) begin : watchdog
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || wr_en)
			stalled_cycles <= 0;
		else
			stalled_cycles <= stalled_cycles + 1;
		if (stalled_cycles >= STALL_LIMIT) begin
			$display("Timeout after %0d cycles without progress", stalled_cycles);
			$display("Verification failed");
			$finish;
		end
	end

	initial begin : test_sequence
		rd_slot = 0;
		wr_slot = 0;
		held = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_register_extremes();
		test_zero_capacity();
		test_oversized_capacity();
		test_output_backpressure();
		test_random_traffic();
		wait_until_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Covered %0d requests and %0d results over %0d register writes,",
			requests_sent, results_seen, config_writes);
		$display("including zero, minimum and oversized capacity and an output hold-off.");
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0d mismatches, %0d results outstanding", mismatches,
				expected_results.size());
			$display("Verification failed");
		end
		$finish;
	end

endmodule
